// File: rtl/ttc_eb_pkg.sv
// ----------------------------------------------------------------------------
// ttc_eb_pkg
// shared types, register codes, sizes and the cosine table builder for the
// time-to-collision emergency brake
// ----------------------------------------------------------------------------
package ttc_eb_pkg;

  // beams per scan that are tested and counted
  localparam int unsigned MaxBeams   = 2048;
  localparam int unsigned IdxW       = $clog2(MaxBeams + 1);
  // cosine table entries over one turn
  localparam int unsigned CosEntries = 256;
  localparam int unsigned CosIdxW    = $clog2(CosEntries);

  // serial multiplier: accumulator and multiplier operand widths
  localparam int unsigned MulW = 47;
  localparam int unsigned MplW = 16;

  localparam int unsigned CntW = 12;
  localparam logic [CntW-1:0] CntMax = '1;

  // quarter-wave sine coefficients, Q14
  localparam longint QOne = 16384;
  localparam longint SinA = 25736;
  localparam longint SinB = 10512;
  localparam longint SinC = 1160;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_TTC_THRESH  = 2'd2;

  localparam logic [15:0] StartAngleRst = 16'hAAAB;
  localparam logic [11:0] AngleStepRst  = 12'd64;
  localparam logic [15:0] TtcThreshRst  = 16'd400;

  typedef struct packed {
    logic [15:0] start_angle;
    logic [11:0] angle_step;
    logic [15:0] ttc_threshold_ms;
  } cfg_t;

  typedef logic signed [15:0] cos_tab_t [CosEntries];

  function automatic longint quarter_sine(longint u);
    longint z2;
    longint t;
    longint t3;
    longint s;
    z2 = (u * u) >>> 14;
    t  = (SinC * z2) >>> 14;
    t3 = (z2 * (SinB - t)) >>> 14;
    s  = (u * (SinA - t3)) >>> 14;
    return (s > QOne) ? QOne : s;
  endfunction

  function automatic longint cos_of_angle(longint theta);
    longint q;
    longint r;
    longint c;
    q = (theta >>> 14) & 3;
    r = theta & 16383;
    case (q)
      0:       c = quarter_sine(QOne - r);
      1:       c = -quarter_sine(r);
      2:       c = -quarter_sine(QOne - r);
      default: c = quarter_sine(r);
    endcase
    return c;
  endfunction

  // evaluated at elaboration only
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int k = 0; k < CosEntries; k++) begin
      tab[k] = 16'(cos_of_angle((longint'(k) <<< 16) / CosEntries));
    end
    return tab;
  endfunction

endpackage

// File: rtl/ttc_eb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ttc_eb_cfg_regs
// configuration register file: start angle, angle step and threshold
// ----------------------------------------------------------------------------
module ttc_eb_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ttc_eb_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [15:0]                        cfg_wdata_i,
  output ttc_eb_pkg::cfg_t                   cfg_o
);

  ttc_eb_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        ttc_eb_pkg::CFG_START_ANGLE: cfg_d.start_angle      = cfg_wdata_i;
        ttc_eb_pkg::CFG_ANGLE_STEP:  cfg_d.angle_step       = cfg_wdata_i[11:0];
        ttc_eb_pkg::CFG_TTC_THRESH:  cfg_d.ttc_threshold_ms = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle      <= ttc_eb_pkg::StartAngleRst;
      cfg_q.angle_step       <= ttc_eb_pkg::AngleStepRst;
      cfg_q.ttc_threshold_ms <= ttc_eb_pkg::TtcThreshRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/ttc_eb_cos_rom.sv
// ----------------------------------------------------------------------------
// ttc_eb_cos_rom
// cosine lookup in Q14 with registered read data
// ----------------------------------------------------------------------------
module ttc_eb_cos_rom (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] cos_o
);

  localparam ttc_eb_pkg::cos_tab_t CosTab = ttc_eb_pkg::build_cos_tab();
  localparam int unsigned ScaleW = 17 + ttc_eb_pkg::CosIdxW;

  logic [ScaleW-1:0]                 scaled;
  logic [ttc_eb_pkg::CosIdxW-1:0]    tab_idx;
  logic signed [15:0]                cos_q;

  // entry = angle * entries / one turn
  assign scaled  = ScaleW'(angle_i) * ScaleW'(ttc_eb_pkg::CosEntries);
  assign tab_idx = scaled[16 +: ttc_eb_pkg::CosIdxW];

  always_ff @(posedge clk_i) begin
    cos_q <= CosTab[tab_idx];
  end

  assign cos_o = cos_q;

endmodule

// File: rtl/ttc_eb_serial_mult.sv
// ----------------------------------------------------------------------------
// ttc_eb_serial_mult
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module ttc_eb_serial_mult (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ttc_eb_pkg::MulW-1:0]     mcand_i,
  input  logic [ttc_eb_pkg::MplW-1:0]     mplier_i,
  output logic                            done_o,
  output logic [ttc_eb_pkg::MulW-1:0]     product_o
);

  logic [ttc_eb_pkg::MulW-1:0] acc_q, acc_d;
  logic [ttc_eb_pkg::MulW-1:0] mc_q, mc_d;
  logic [ttc_eb_pkg::MplW-1:0] mp_q, mp_d;
  logic                        run_q, run_d;

  // finishes as soon as no multiplier bits remain
  assign done_o    = run_q && (mp_q == '0);
  assign product_o = acc_q;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    run_d = run_q;
    if (start_i) begin
      acc_d = '0;
      mc_d  = mcand_i;
      mp_d  = mplier_i;
      run_d = 1'b1;
    end else if (run_q) begin
      if (mp_q == '0) begin
        run_d = 1'b0;
      end else begin
        if (mp_q[0]) begin
          acc_d = acc_q + mc_q;
        end
        mc_d = {mc_q[ttc_eb_pkg::MulW-2:0], 1'b0};
        mp_d = {1'b0, mp_q[ttc_eb_pkg::MplW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q  <= '0;
      run_q <= 1'b0;
    end else begin
      mp_q  <= mp_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
  end

endmodule

// File: rtl/ttc_emergency_brake.sv
// ----------------------------------------------------------------------------
// ttc_emergency_brake
// time-to-collision emergency brake over a stream of lidar beams
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): opcode 0 stores speed_value_i as
// the forward speed; opcode 1 brings one beam range. Each beam that is valid
// and within the first MaxBeams slots of the scan is tested: its angle comes
// from start_angle + index * angle_step, the cosine from a table, and braking
// is requested when range * 1000 * 16384 < threshold * speed * cos.
// On a beam with last_beam_i set, one transaction leaves on the output
// channel (out_valid_o / out_stall_i) with brake_o and valid_beams_o, and the
// scan state clears; the stored speed stays.
// Sequencing: tested beams share one bit-serial multiplier that runs up to
// three products per beam (angle, speed times cosine, times threshold), one
// multiplier bit per cycle, ending early when the remaining bits are zero;
// a beam that is not closing stops after the angle product. A last beam
// passes through an emit state that hands over the result.
// The output register lets a new item be taken while a result waits; a last
// beam that finishes while the previous result is still stalled holds the
// block until that result is taken. Reset clears speed and scan state and
// loads the configuration defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module ttc_emergency_brake (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ttc_eb_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]                     cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic signed [15:0]              speed_value_i,
  input  logic [15:0]                     beam_range_i,
  input  logic                            beam_invalid_i,
  input  logic                            last_beam_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            brake_o,
  output logic [11:0]                     valid_beams_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ANGLE = 3'd1;
  localparam logic [2:0] ST_COS   = 3'd2;
  localparam logic [2:0] ST_SPCOS = 3'd3;
  localparam logic [2:0] ST_RHS   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam int unsigned IdxW = ttc_eb_pkg::IdxW;
  localparam int unsigned MulW = ttc_eb_pkg::MulW;
  localparam int unsigned MplW = ttc_eb_pkg::MplW;
  localparam int unsigned CntW = ttc_eb_pkg::CntW;

  ttc_eb_pkg::cfg_t cfg;

  logic [2:0]            state_q, state_d;
  logic signed [15:0]    speed_q, speed_d;
  logic [IdxW-1:0]       beam_index_q, beam_index_d;
  logic                  brake_seen_q, brake_seen_d;
  logic [CntW-1:0]       valid_count_q, valid_count_d;
  logic                  last_q, last_d;
  logic                  adv_q, adv_d;
  logic                  tested_q, tested_d;
  logic [MulW-1:0]       lhs_q, lhs_d;
  logic                  out_valid_q, out_valid_d;
  logic                  brake_q, brake_d;
  logic [CntW-1:0]       valid_beams_q, valid_beams_d;

  logic                  in_accept;
  logic                  slot_free;
  logic [25:0]           range_x1000;
  logic                  mul_start;
  logic [MulW-1:0]       mul_mcand;
  logic [MplW-1:0]       mul_mplier;
  logic                  mul_done;
  logic [MulW-1:0]       mul_product;
  logic [15:0]           beam_angle;
  logic signed [15:0]    cos_val;
  logic                  closing;
  logic [15:0]           speed_mag;
  logic [15:0]           cos_mag;
  logic                  emit_load;

  ttc_eb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ttc_eb_serial_mult u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  // angle wraps modulo one turn
  assign beam_angle = cfg.start_angle + mul_product[15:0];

  ttc_eb_cos_rom u_cos (
    .clk_i   (clk_i),
    .angle_i (beam_angle),
    .cos_o   (cos_val)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = (beam_index_q < IdxW'(ttc_eb_pkg::MaxBeams));

  // range * 1000 = range * (1024 - 16 - 8)
  assign range_x1000 = 26'({beam_range_i, 10'b0}) - 26'({beam_range_i, 4'b0})
                     - 26'({beam_range_i, 3'b0});

  assign closing   = ((speed_q > 16'sd0) && (cos_val > 16'sd0)) ||
                     ((speed_q < 16'sd0) && (cos_val < 16'sd0));
  assign speed_mag = speed_q[15] ? 16'(-speed_q) : 16'(speed_q);
  assign cos_mag   = cos_val[15] ? 16'(-cos_val) : 16'(cos_val);

  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    speed_d       = speed_q;
    beam_index_d  = beam_index_q;
    brake_seen_d  = brake_seen_q;
    valid_count_d = valid_count_q;
    last_d        = last_q;
    adv_d         = adv_q;
    tested_d      = tested_q;
    lhs_d         = lhs_q;
    mul_start     = 1'b0;
    mul_mcand     = '0;
    mul_mplier    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!opcode_i) begin
            speed_d = speed_value_i;
          end else begin
            last_d   = last_beam_i;
            adv_d    = slot_free;
            tested_d = slot_free && !beam_invalid_i;
            lhs_d    = MulW'({range_x1000, 14'b0});
            if (slot_free && !beam_invalid_i) begin
              // index * step, low 16 bits give the angle offset
              mul_start  = 1'b1;
              mul_mcand  = MulW'(cfg.angle_step);
              mul_mplier = MplW'(beam_index_q);
              state_d    = ST_ANGLE;
            end else begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_ANGLE: begin
        if (mul_done) begin
          state_d = ST_COS;
        end
      end
      ST_COS: begin
        if (closing) begin
          mul_start  = 1'b1;
          mul_mcand  = MulW'(speed_mag);
          mul_mplier = MplW'(cos_mag);
          state_d    = ST_SPCOS;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SPCOS: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = mul_product;
          mul_mplier = MplW'(cfg.ttc_threshold_ms);
          state_d    = ST_RHS;
        end
      end
      ST_RHS: begin
        if (mul_done) begin
          if (lhs_q < mul_product) begin
            brake_seen_d = 1'b1;
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (adv_q) begin
          beam_index_d = beam_index_q + IdxW'(1);
        end
        if (tested_q && (valid_count_q != ttc_eb_pkg::CntMax)) begin
          valid_count_d = valid_count_q + CntW'(1);
        end
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load) begin
          beam_index_d  = '0;
          brake_seen_d  = 1'b0;
          valid_count_d = '0;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d   = out_valid_q;
    brake_d       = brake_q;
    valid_beams_d = valid_beams_q;
    if (emit_load) begin
      out_valid_d   = 1'b1;
      brake_d       = brake_seen_q;
      valid_beams_d = valid_count_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      speed_q       <= '0;
      beam_index_q  <= '0;
      brake_seen_q  <= 1'b0;
      valid_count_q <= '0;
      last_q        <= 1'b0;
      adv_q         <= 1'b0;
      tested_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      speed_q       <= speed_d;
      beam_index_q  <= beam_index_d;
      brake_seen_q  <= brake_seen_d;
      valid_count_q <= valid_count_d;
      last_q        <= last_d;
      adv_q         <= adv_d;
      tested_q      <= tested_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q         <= lhs_d;
    brake_q       <= brake_d;
    valid_beams_q <= valid_beams_d;
  end

  assign out_valid_o   = out_valid_q;
  assign brake_o       = brake_q;
  assign valid_beams_o = valid_beams_q;

`ifndef ASSERT_OFF
  // counted beams never outnumber used angle slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(valid_count_q) <= CntW'(beam_index_q))
    else $error("valid beam count exceeds beam index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beam_index_q <= IdxW'(ttc_eb_pkg::MaxBeams))
    else $error("beam index beyond scan limit");

  // multiplier only completes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_ANGLE || state_q == ST_SPCOS || state_q == ST_RHS))
    else $error("multiplier finished outside a multiply step");

  // a handed-over result leaves the scan state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (out_valid_q && !brake_seen_q && valid_count_q == '0 &&
                   beam_index_q == '0 && state_q == ST_IDLE))
    else $error("scan state not cleared after result");
`endif

endmodule

// File: tb/ttc_emergency_brake_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttc_emergency_brake_checker
// follows the configuration, input and result channels of the brake block,
// keeps its own copy of speed, scan and register state, works out the brake
// flag and valid beam count of every scan and checks them against the results
// ----------------------------------------------------------------------------
package ttc_eb_tb_pkg;

  typedef enum logic {
    OP_SPEED = 1'b0,
    OP_BEAM  = 1'b1
  } opcode_e;

endpackage

module ttc_emergency_brake_checker
  import ttc_eb_pkg::*;
  import ttc_eb_tb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                opcode_i,
  input  logic signed [15:0]  speed_value_i,
  input  logic [15:0]         beam_range_i,
  input  logic                beam_invalid_i,
  input  logic                last_beam_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                brake_i,
  input  logic [11:0]         valid_beams_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam longint Q14One   = 16384;
  localparam longint QuarterA = 25736;
  localparam longint QuarterB = 10512;
  localparam longint QuarterC = 1160;

  typedef struct packed {
    logic        brake;
    logic [11:0] valid_beams;
  } scan_result_t;

  logic signed [15:0] cos_q14 [CosEntries];

  logic [15:0]        start_angle_q;
  logic [11:0]        angle_step_q;
  logic [15:0]        threshold_q;
  logic signed [15:0] speed_q;
  int unsigned        slot_q;
  logic               brake_q;
  logic [CntW-1:0]    counted_q;

  scan_result_t scan_results_q [$];

  // polynomial sine over a quarter turn, u and result in Q14
  function automatic longint quarter_wave(longint u);
    longint zsq;
    longint inner;
    longint outer;
    longint s;
    zsq   = (u * u) >> 14;
    inner = QuarterB - ((QuarterC * zsq) >> 14);
    outer = QuarterA - ((zsq * inner) >> 14);
    s     = (u * outer) >> 14;
    return (s > Q14One) ? Q14One : s;
  endfunction

  function automatic longint cos_at(logic [15:0] theta);
    longint r;
    longint c;
    r = longint'(theta[13:0]);
    case (theta[15:14])
      2'd0:    c = quarter_wave(Q14One - r);
      2'd1:    c = -quarter_wave(r);
      2'd2:    c = -quarter_wave(Q14One - r);
      default: c = quarter_wave(r);
    endcase
    return c;
  endfunction

  initial begin
    for (int k = 0; k < CosEntries; k++) begin
      cos_q14[k] = 16'(cos_at(16'((longint'(k) << 16) / CosEntries)));
    end
  end

  // range * 1000 * 1.0 below threshold * speed * cos, closing speed positive
  function automatic logic closing_too_fast(logic [15:0] range_mm);
    logic [15:0]     angle;
    int unsigned     idx;
    longint          c;
    longint          sp;
    longint          cm;
    longint unsigned lhs;
    longint unsigned rhs;
    angle = start_angle_q + 16'(slot_q * angle_step_q);
    idx   = (int'(angle) * CosEntries) >> 16;
    c     = longint'(cos_q14[idx]);
    if (!((speed_q > 0 && c > 0) || (speed_q < 0 && c < 0))) return 1'b0;
    sp  = (speed_q < 0) ? -longint'(speed_q) : longint'(speed_q);
    cm  = (c < 0) ? -c : c;
    lhs = longint'(range_mm) * 1000 * Q14One;
    rhs = longint'(threshold_q) * sp * cm;
    return lhs < rhs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      start_angle_q = StartAngleRst;
      angle_step_q  = AngleStepRst;
      threshold_q   = TtcThreshRst;
      speed_q       = '0;
      slot_q        = 0;
      brake_q       = 1'b0;
      counted_q     = '0;
      scan_results_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_START_ANGLE: start_angle_q = cfg_wdata_i;
          CFG_ANGLE_STEP:  angle_step_q  = cfg_wdata_i[11:0];
          CFG_TTC_THRESH:  threshold_q   = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_SPEED) begin
          speed_q = speed_value_i;
        end else begin
          // beams past the table of slots are not looked at, though a last one still ends the scan
          if (slot_q < MaxBeams) begin
            if (!beam_invalid_i) begin
              if (closing_too_fast(beam_range_i)) brake_q = 1'b1;
              if (counted_q != CntMax) counted_q++;
            end
            slot_q++;
          end
          if (last_beam_i) begin
            want = '{brake: brake_q, valid_beams: counted_q};
            scan_results_q.insert(scan_results_q.size(), want);
            slot_q    = 0;
            brake_q   = 1'b0;
            counted_q = '0;
          end
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (scan_results_q.size() == 0) begin
          $error("unexpected result: brake %0d valid_beams %0d", brake_i, valid_beams_i);
          fail_count_o++;
        end else begin
          want = scan_results_q.pop_front();
          if (brake_i !== want.brake) begin
            $error("brake: expected %0d, actual %0d", want.brake, brake_i);
            fail_count_o++;
          end
          if (valid_beams_i !== want.valid_beams) begin
            $error("valid_beams: expected %0d, actual %0d", want.valid_beams, valid_beams_i);
            fail_count_o++;
          end
        end
      end

      pending_o = scan_results_q.size();
    end
  end

endmodule

// File: tb/ttc_emergency_brake_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttc_emergency_brake_test
// drives speed updates and lidar scans into the brake block under a range of
// angle, step and threshold settings and idling patterns; the checker beside
// the block predicts every scan result and counts mismatches
// ----------------------------------------------------------------------------
module ttc_emergency_brake_test;
  import ttc_eb_pkg::*;
  import ttc_eb_tb_pkg::*;

  localparam int ItemsPerPhase = 185;
  localparam int NumPhases     = 8;
  localparam int SettleCycles  = 64;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i     = '0;
  logic [15:0]         cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                opcode_i       = 1'b0;
  logic signed [15:0]  speed_value_i  = '0;
  logic [15:0]         beam_range_i   = '0;
  logic                beam_invalid_i = 1'b0;
  logic                last_beam_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                brake_o;
  logic [11:0]         valid_beams_o;

  int fail_count;
  int pending;
  int items_sent;
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;
  int idle_pct  = 0;

  ttc_emergency_brake dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .speed_value_i (speed_value_i),
    .beam_range_i  (beam_range_i),
    .beam_invalid_i(beam_invalid_i),
    .last_beam_i   (last_beam_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .brake_o       (brake_o),
    .valid_beams_o (valid_beams_o)
  );

  ttc_emergency_brake_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .speed_value_i (speed_value_i),
    .beam_range_i  (beam_range_i),
    .beam_invalid_i(beam_invalid_i),
    .last_beam_i   (last_beam_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .brake_i       (brake_o),
    .valid_beams_i (valid_beams_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= stalls_on && ($urandom_range(99) < idle_pct);
  end

  task automatic set_idling(int mode);
    case (mode)
      1:       begin gaps_on = 1'b1; stalls_on = 1'b0; idle_pct = 58; end
      2:       begin gaps_on = 1'b0; stalls_on = 1'b1; idle_pct = 58; end
      3:       begin gaps_on = 1'b1; stalls_on = 1'b1; idle_pct = 6;  end
      default: begin gaps_on = 1'b0; stalls_on = 1'b0; idle_pct = 0;  end
    endcase
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] start, logic [11:0] step, logic [15:0] thresh);
    write_reg(CFG_START_ANGLE, start);
    write_reg(CFG_ANGLE_STEP, {4'b0, step});
    write_reg(CFG_TTC_THRESH, thresh);
  endtask

  task automatic present(opcode_e op, logic [15:0] speed, logic [15:0] range_mm,
                         logic invalid, logic last);
    while (gaps_on && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    speed_value_i  <= speed;
    beam_range_i   <= range_mm;
    beam_invalid_i <= invalid;
    last_beam_i    <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // unused fields carry random values so they are seen to be ignored
  task automatic speed_update(logic [15:0] speed);
    present(OP_SPEED, speed, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic beam(logic [15:0] range_mm, logic invalid, logic last);
    present(OP_BEAM, 16'($urandom), range_mm, invalid, last);
  endtask

  // lets the block drain and finish any beam still in the multiplier
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_speed();
    if ($urandom_range(3) == 0) return 16'($urandom_range(0, 4000) - 2000);
    return 16'($urandom);
  endfunction

  // short ranges so that braking happens often enough
  function automatic logic [15:0] random_range();
    if ($urandom_range(1)) return 16'($urandom_range(0, 4095));
    return 16'($urandom);
  endfunction

  task automatic random_scan();
    int len;
    bit all_invalid;
    len         = ($urandom_range(15) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    all_invalid = ($urandom_range(9) == 0);
    if ($urandom_range(1)) speed_update(random_speed());
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) speed_update(random_speed());
      beam(random_range(), all_invalid || ($urandom_range(7) == 0), i == len - 1);
    end
  endtask

  task automatic configure_phase(int phase);
    case (phase)
      0:       write_all(16'h8000, 12'd0, 16'd0);
      1:       write_all(16'h7FFF, 12'hFFF, 16'hFFFF);
      2:       write_all(16'($urandom), 12'($urandom), 16'($urandom_range(200, 2000)));
      3:       write_all(16'h0000, 12'd1, 16'd400);
      default: write_all(16'($urandom), 12'($urandom), 16'($urandom));
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: beams point backwards, only negative speed closes in
    beam(16'd0, 1'b0, 1'b1);
    speed_update(16'h7FFF);
    beam(16'd0, 1'b0, 1'b1);
    speed_update(16'h8000);
    beam(16'hFFFF, 1'b0, 1'b0);
    beam(16'd0, 1'b1, 1'b0);
    beam(16'd0, 1'b0, 1'b1);
    // scan with no valid beam
    beam(16'hFFFF, 1'b1, 1'b1);
    // speed changes in the middle of a scan
    speed_update(-16'sd20000);
    beam(16'd1000, 1'b0, 1'b0);
    speed_update(16'sd20000);
    beam(16'd0, 1'b0, 1'b1);
    settle();

    write_all(16'h0000, 12'd0, 16'hFFFF);
    speed_update(16'h7FFF);
    beam(16'hFFFF, 1'b0, 1'b0);
    beam(16'd0, 1'b1, 1'b0);
    beam(16'hFFFF, 1'b0, 1'b1);
    settle();
    // zero threshold never brakes
    write_reg(CFG_TTC_THRESH, 16'd0);
    beam(16'd0, 1'b0, 1'b1);
    settle();
    write_all(16'h7FFF, 12'hFFF, 16'd5000);
    speed_update(-16'sd1);
    beam(16'd0, 1'b0, 1'b0);
    beam(16'd1, 1'b0, 1'b0);
    beam(16'd0, 1'b0, 1'b1);
    settle();

    for (int phase = 0; phase < NumPhases; phase++) begin
      configure_phase(phase);
      set_idling(phase % 4);
      items_sent = 0;
      while (items_sent < ItemsPerPhase) random_scan();
      settle();
    end

    set_idling(0);
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
